// ===== sv/cddh_pkg.sv =====
`default_nettype none

package cddh_pkg;

  localparam int unsigned MinW         = 7;
  localparam int unsigned SecW         = 6;
  localparam int unsigned TimeW        = 13;
  localparam int unsigned TrackW       = 7;
  localparam int unsigned TotalW       = 8;
  localparam int unsigned PlayW        = 16;
  localparam int unsigned IdW          = 32;
  localparam int unsigned HundW        = 7;
  localparam int unsigned DsW          = 5;
  localparam int unsigned DefMaxTracks = 99;
  localparam int unsigned MidDepth     = 2;
  localparam int unsigned OutDepth     = 2;

  localparam logic [TimeW-1:0]  SecsPerMin   = 13'd60;
  localparam logic [TimeW-1:0]  RecipHund    = 13'd5243;
  localparam int unsigned       RecipShift   = 19;
  localparam logic [HundW-1:0]  Hundred      = 7'd100;
  localparam logic [TotalW:0]   TotalMod     = 9'd255;

  typedef logic [DsW-1:0] ds_tbl_t [2**HundW];

  typedef struct packed {
    logic [TimeW-1:0] secs;
    logic             leadout;
  } entry_t;

  typedef struct packed {
    logic [IdW-1:0]    disc_id;
    logic [TrackW-1:0] track_total;
    logic              order_error;
  } result_t;

  function automatic ds_tbl_t build_ds_tbl();
    ds_tbl_t    tbl;
    int unsigned ones;
    int unsigned tens;
    int unsigned hunds;
    ones  = 0;
    tens  = 0;
    hunds = 0;
    for (int unsigned i = 0; i < 2**HundW; i++) begin
      tbl[i] = DsW'(ones + tens + hunds);
      if (ones == 9) begin
        ones = 0;
        if (tens == 9) begin
          tens  = 0;
          hunds = hunds + 1;
        end else begin
          tens = tens + 1;
        end
      end else begin
        ones = ones + 1;
      end
    end
    return tbl;
  endfunction

  localparam ds_tbl_t DsTbl = build_ds_tbl();

endpackage

`default_nettype wire

// ===== sv/cd_disc_id_hash.sv =====
// channel    handshake           payload
// ---------  ------------------  ------------------------------------------
// entry in   push / full         minutes_i, seconds_i, is_leadout_i
// result out empty / pop         disc_id_o, track_total_o, order_error_o
//
// one entry per cycle unless a lead-out waits on a full result queue; a lead-out
// passes the entry queue, hundreds split, then digit-sum accumulate and write
// two-entry queues sit between front and back and after the back
// rst_ni clears the running disc state and both queues at once
// a full result queue holds a lead-out in the back stage; entries behind it
// wait, and full rises once the entry queue fills
`default_nettype none

module cd_disc_id_hash
  import cddh_pkg::*;
#(
  parameter int unsigned MAX_TRACKS = DefMaxTracks
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [MinW-1:0]   minutes_i,
  input  wire logic [SecW-1:0]   seconds_i,
  input  wire logic              is_leadout_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [IdW-1:0]         disc_id_o,
  output logic [TrackW-1:0]      track_total_o,
  output logic                   order_error_o
);

  logic    mid_empty;
  logic    mid_rd;
  entry_t  mid_entry;
  logic    res_wr;
  logic    res_full;
  result_t res_in;
  result_t res_out;
  logic [$bits(result_t)-1:0] res_rdata;

  cddh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .minutes_i    (minutes_i),
    .seconds_i    (seconds_i),
    .is_leadout_i (is_leadout_i),
    .rd_i         (mid_rd),
    .empty_o      (mid_empty),
    .entry_o      (mid_entry)
  );

  cddh_back #(
    .MaxTracks (MAX_TRACKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_entry_i (mid_entry),
    .mid_rd_o    (mid_rd),
    .res_wr_o    (res_wr),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  cddh_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .empty_o (empty),
    .rdata_o (res_rdata)
  );

  assign res_out       = result_t'(res_rdata);
  assign disc_id_o     = res_out.disc_id;
  assign track_total_o = res_out.track_total;
  assign order_error_o = res_out.order_error;

endmodule

`default_nettype wire

// ===== sv/cddh_fifo.sv =====
`default_nettype none

module cddh_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic                  empty_o,
  output logic [Width-1:0]      rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem[rptr_q];

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wptr_d = do_wr ? next_ptr(wptr_q) : wptr_q;
    rptr_d = do_rd ? next_ptr(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cddh_front.sv =====
`default_nettype none

module cddh_front
  import cddh_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [MinW-1:0]  minutes_i,
  input  wire logic [SecW-1:0]  seconds_i,
  input  wire logic             is_leadout_i,
  input  wire logic             rd_i,
  output logic                  empty_o,
  output entry_t                entry_o
);

  entry_t                 entry_in;
  logic [$bits(entry_t)-1:0] rdata;

  // minute/second address to seconds
  always_comb begin
    entry_in.secs    = TimeW'(minutes_i) * SecsPerMin + TimeW'(seconds_i);
    entry_in.leadout = is_leadout_i;
  end

  cddh_fifo #(
    .Width ($bits(entry_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push_i),
    .wdata_i (entry_in),
    .full_o  (full_o),
    .rd_i    (rd_i),
    .empty_o (empty_o),
    .rdata_o (rdata)
  );

  assign entry_o = entry_t'(rdata);

endmodule

`default_nettype wire

// ===== sv/cddh_back.sv =====
`default_nettype none

module cddh_back
  import cddh_pkg::*;
#(
  parameter int unsigned MaxTracks = DefMaxTracks
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   mid_empty_i,
  input  wire entry_t mid_entry_i,
  output logic        mid_rd_o,
  output logic        res_wr_o,
  output result_t     res_o,
  input  wire logic   res_full_i
);

  // stage a: split seconds into hundreds and remainder
  logic               a_valid_q;
  logic               a_lead_q;
  logic [TimeW-1:0]   a_secs_q;
  logic [HundW-1:0]   a_hund_q;
  logic [2*TimeW-1:0] prod;
  logic               a_done;
  logic               a_load;

  // running disc state
  logic [TotalW-1:0]  total_q, total_d;
  logic [TimeW-1:0]   first_q, first_d;
  logic [TrackW-1:0]  cnt_q, cnt_d;
  logic               ovf_q, ovf_d;

  logic [TimeW-1:0]   hund_x100;
  logic [HundW-1:0]   rem;
  logic [DsW:0]       dsum;
  logic [TotalW:0]    sum;
  logic [TimeW-1:0]   play;
  logic               late;

  assign prod     = TimeW'(mid_entry_i.secs) * RecipHund;
  assign a_done   = a_valid_q && (!a_lead_q || !res_full_i);
  assign a_load   = !a_valid_q || a_done;
  assign mid_rd_o = a_load && !mid_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_load) begin
      a_valid_q <= !mid_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_rd_o) begin
      a_lead_q <= mid_entry_i.leadout;
      a_secs_q <= mid_entry_i.secs;
      a_hund_q <= prod[RecipShift +: HundW];
    end
  end

  always_comb begin
    hund_x100 = TimeW'(a_hund_q) * TimeW'(Hundred);
    rem       = HundW'(a_secs_q - hund_x100);
    dsum      = (DsW+1)'(DsTbl[a_hund_q]) + (DsW+1)'(DsTbl[rem]);
    sum       = (TotalW+1)'(total_q) + (TotalW+1)'(dsum);
    late      = (cnt_q != '0) && (a_secs_q < first_q);
    play      = ((cnt_q != '0) && !late) ? a_secs_q - first_q : '0;

    total_d = total_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    if (a_done) begin
      if (a_lead_q) begin
        total_d = '0;
        first_d = '0;
        cnt_d   = '0;
        ovf_d   = 1'b0;
      end else begin
        total_d = (sum >= TotalMod) ? TotalW'(sum - TotalMod) : TotalW'(sum);
        if (cnt_q == '0) begin
          first_d = a_secs_q;
        end
        if (cnt_q < TrackW'(MaxTracks)) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end
    end

    res_wr_o          = a_done && a_lead_q;
    res_o.disc_id     = {total_q, PlayW'(play), TotalW'(cnt_q)};
    res_o.track_total = cnt_q;
    res_o.order_error = ovf_q || late;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      first_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      total_q <= total_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire
